>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the extrema counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HEC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/hec_pkg.sv
// Types and constants shared by the hysteresis extrema counter.
`default_nettype none
package hec_pkg;

   // Width of the tolerance register.
   localparam int TOL_BITS = 31;
   // Width of the count field in the result.
   localparam int OUT_COUNT_BITS = 16;

   // Fields of one input request.
   typedef struct packed {
      logic signed [31:0] sample;
      logic               first_of_series;
      logic               last_of_series;
   } req_type;

   // Fields of one result.
   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0] extrema_count;
      logic                      is_final;
   } rsp_type;

   // Direction of travel of the series.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_RISE = 2'd1,
      DIR_FALL = 2'd2
   } dir_type;

endpackage
`default_nettype wire

>>> hdl/hec_in_reg.sv
// Input register stage: holds one accepted request for the core.
`default_nettype none
module hec_in_reg (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   input  hec_pkg::req_type req_payload,
   input  wire             advance,
   output logic            item_valid,
   output hec_pkg::req_type item
);
   import hec_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    accept;

   // The stage is free when empty or when the core takes its request this cycle.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

>>> hdl/hec_core.sv
// Series state and the per-sample update of the extrema count.
`default_nettype none
module hec_core #(
   parameter int COUNT_BITS  = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [hec_pkg::TOL_BITS-1:0]      tolerance,
   input  wire                               fire,
   input  hec_pkg::req_type                  item,
   output logic                              result_valid,
   output hec_pkg::rsp_type                  result
);
   import hec_pkg::*;

   // Width of a difference compare: difference of two samples or the tolerance.
   localparam int DW = (SAMPLE_BITS + 1 > TOL_BITS) ? SAMPLE_BITS + 1 : TOL_BITS;
   // Count width widened so that the result field can always be taken from it.
   localparam int CW = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   logic signed [SAMPLE_BITS-1:0] k;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0] trk_ff, trk_in;
   logic signed [SAMPLE_BITS-1:0] new_min, new_max;
   dir_type                       dir_ff, dir_in, step_dir;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in, cnt_inc;
   logic                          open_ff, open_in;
   logic [SAMPLE_BITS:0]          down_diff, up_diff, range_diff;
   logic [DW-1:0]                 tol_ext;
   logic                          start;
   logic [CW-1:0]                 cnt_wide;

   // Sign-extend or truncate the sample field to the working width.
   if (SAMPLE_BITS <= 32) begin : g_narrow
      assign k = item.sample[SAMPLE_BITS-1:0];
   end else begin : g_wide
      assign k = {{(SAMPLE_BITS-32){item.sample[31]}}, item.sample};
   end

   assign tol_ext = DW'(tolerance);
   assign start   = item.first_of_series || !open_ff;
   assign cnt_inc = (cnt_ff == {COUNT_BITS{1'b1}}) ? cnt_ff : cnt_ff + 1'b1;

   // Running range while the direction is still open.
   assign new_max    = (k > max_ff) ? k : max_ff;
   assign new_min    = (k > max_ff) ? min_ff : ((k < min_ff) ? k : min_ff);
   assign range_diff = {new_max[SAMPLE_BITS-1], new_max} - {new_min[SAMPLE_BITS-1], new_min};
   // Distances from the tracked extremum; each is used only when nonnegative.
   assign down_diff  = {trk_ff[SAMPLE_BITS-1], trk_ff} - {k[SAMPLE_BITS-1], k};
   assign up_diff    = {k[SAMPLE_BITS-1], k} - {trk_ff[SAMPLE_BITS-1], trk_ff};

   // Sign of the step from the previous sample.
   always_comb begin
      if (k > prev_ff) begin
         step_dir = DIR_RISE;
      end else if (k < prev_ff) begin
         step_dir = DIR_FALL;
      end else begin
         step_dir = DIR_NONE;
      end
   end

   // Next state for one sample.
   always_comb begin
      prev_in = prev_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      trk_in  = trk_ff;
      dir_in  = dir_ff;
      cnt_in  = cnt_ff;
      open_in = open_ff;
      if (start) begin
         prev_in = k;
         min_in  = k;
         max_in  = k;
         trk_in  = k;
         dir_in  = DIR_NONE;
         cnt_in  = '0;
         open_in = 1'b1;
      end else begin
         prev_in = k;
         if (tolerance == '0) begin
            // Strict mode: count each reversal of the nonzero step sign.
            if (step_dir != DIR_NONE) begin
               if (dir_ff != DIR_NONE && dir_ff != step_dir) begin
                  cnt_in = cnt_inc;
               end
               dir_in = step_dir;
            end
         end else begin
            // Tolerant mode: follow the extremum, turn on a large enough move back.
            unique case (dir_ff)
               DIR_RISE: begin
                  if (k > trk_ff) begin
                     trk_in = k;
                  end else if (DW'(down_diff) > tol_ext) begin
                     dir_in = DIR_FALL;
                     trk_in = k;
                     cnt_in = cnt_inc;
                  end
               end
               DIR_FALL: begin
                  if (k <= trk_ff) begin
                     trk_in = k;
                  end else if (DW'(up_diff) > tol_ext) begin
                     dir_in = DIR_RISE;
                     trk_in = k;
                     cnt_in = cnt_inc;
                  end
               end
               default: begin
                  max_in = new_max;
                  min_in = new_min;
                  if (DW'(range_diff) > tol_ext) begin
                     dir_in = (k == new_max) ? DIR_RISE : DIR_FALL;
                     trk_in = k;
                  end
               end
            endcase
         end
      end
      if (item.last_of_series) begin
         open_in = 1'b0;
      end
   end

   // Series state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
         trk_ff  <= '0;
         dir_ff  <= DIR_NONE;
         cnt_ff  <= '0;
         open_ff <= 1'b0;
      end else if (fire) begin
         prev_ff <= prev_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         trk_ff  <= trk_in;
         dir_ff  <= dir_in;
         cnt_ff  <= cnt_in;
         open_ff <= open_in;
      end
   end

   // Result of this sample, meaningful only on the last sample of a series.
   assign cnt_wide             = CW'(cnt_in);
   assign result_valid         = fire && item.last_of_series;
   assign result.extrema_count = cnt_wide[OUT_COUNT_BITS-1:0];
   assign result.is_final      = 1'b1;

endmodule
`default_nettype wire

>>> hdl/hec_out_reg.sv
// Result register: holds a finished count until the receiver takes it.
`default_nettype none
module hec_out_reg (
   input  wire              clock,
   input  wire              reset,
   input  wire              result_valid,
   input  hec_pkg::rsp_type result,
   output logic             advance,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output hec_pkg::rsp_type rsp_payload
);
   import hec_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The core may move whenever the result slot is empty or being emptied.
   assign advance  = !(valid_ff && rsp_stall);
   assign valid_in = advance ? result_valid : valid_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule
`default_nettype wire

>>> hdl/hysteresis_extrema_counter.sv
// Top level of the hysteresis extrema counter.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  sample, first_of_series, last_of_series
//   rsp      out        rsp_valid/rsp_stall  extrema_count, is_final
//   csr      in         csr_wr_en            tolerance (31 bits)
//
// One request per cycle is taken while the result side does not stall; the request with
// last_of_series passes the input and result registers, which then raise rsp_valid.
// Reset is synchronous and clears the tolerance, the series state and both valid flags.
// A stalled result holds the core, and one more request waits in the input register.
`default_nettype none
module hysteresis_extrema_counter #(
   parameter int COUNT_BITS  = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  hec_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output hec_pkg::rsp_type             rsp_payload,
   input  wire                          csr_wr_en,
   input  wire  [hec_pkg::TOL_BITS-1:0] csr_wr_data
);
   import hec_pkg::*;

   logic [TOL_BITS-1:0] tol_ff;
   logic                advance;
   logic                item_valid;
   req_type             item;
   logic                result_valid;
   rsp_type             result;

   // Tolerance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   hec_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   hec_core #(
      .COUNT_BITS  (COUNT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .tolerance    (tol_ff),
      .fire         (item_valid && advance),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   hec_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
`default_nettype wire

>>> hdl/hec_checker.sv
// Port-level checks for the extrema counter and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"
module hec_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input hec_pkg::rsp_type             rsp_payload
);
   import hec_pkg::*;

   // A stalled result stays valid and unchanged.
   `HEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   // Every result marks the end of a series.
   `HEC_ASSERT_IMPL(a_rsp_final, clock, reset, rsp_valid, rsp_payload.is_final)
   // Requests back up only behind a stalled result.
   `HEC_ASSERT_IMPL(a_req_backpressure, clock, reset, req_stall, rsp_valid && rsp_stall)
   // No result is pending right after reset.
   `HEC_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !req_stall)

endmodule

bind hysteresis_extrema_counter hec_checker u_hec_checker (.*);
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the hysteresis extrema counter.
`timescale 1ns / 1ps
module tb;
   import hec_pkg::*;

   // Length of the forced result hold-off, and the overall time limit.
   localparam int      HOLD_CYCLES  = 300;
   localparam longint  TIMEOUT_NS   = 64'd10_000_000;
   localparam longint  SAMPLE_TOP   = 64'sd2147483647;
   localparam longint  SAMPLE_FLOOR = -64'sd2147483648;
   localparam logic [OUT_COUNT_BITS-1:0] COUNT_CEILING = '1;

   // How the samples of one series are drawn.
   typedef enum int {SHAPE_RANDOM, SHAPE_EXTREME, SHAPE_WALK, SHAPE_EDGE} shape_type;
   // How the framing flags of one series are set.
   typedef enum int {FRAME_CLEAN, FRAME_NO_FIRST, FRAME_NO_LAST, FRAME_NOISE} frame_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_wr_en   = 1'b0;
   logic [TOL_BITS-1:0] csr_wr_data = '0;

   // Shadow copy of the counter state and its tolerance setting.
   logic signed [31:0]        shadow_prev;
   logic signed [31:0]        shadow_min;
   logic signed [31:0]        shadow_max;
   logic signed [31:0]        shadow_peak;
   dir_type                   shadow_dir;
   logic [OUT_COUNT_BITS-1:0] shadow_turns;
   bit                        shadow_open;
   logic [TOL_BITS-1:0]       tol_setting;

   logic [OUT_COUNT_BITS-1:0] expected_counts[$];
   int  mismatch_count = 0;
   int  tx_calm        = 0;
   int  rx_calm        = 0;
   bit  burst_mode     = 1'b0;
   bit  hold_pending   = 1'b0;
   bit  hold_active    = 1'b0;

   hysteresis_extrema_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running 100 MHz clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off here if it hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Prints one mismatch and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Picks an idle length: mostly none or short, sometimes long, with calm stretches.
   function automatic int pick_gap(ref int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Advances the shadow state by one accepted request and queues any count it reports.
   function automatic void predict_series_step(input req_type r);
      logic signed [31:0] s;
      dir_type            step_dir;
      s = r.sample;
      if (r.first_of_series || !shadow_open) begin
         shadow_prev  = s;
         shadow_min   = s;
         shadow_max   = s;
         shadow_peak  = s;
         shadow_dir   = DIR_NONE;
         shadow_turns = '0;
         shadow_open  = 1'b1;
      end else begin
         if (tol_setting == 0) begin
            // Strict mode: every reversal of a nonzero step counts.
            step_dir = DIR_NONE;
            if (s > shadow_prev) step_dir = DIR_RISE;
            else if (s < shadow_prev) step_dir = DIR_FALL;
            if (step_dir != DIR_NONE) begin
               if (shadow_dir != DIR_NONE && shadow_dir != step_dir &&
                   shadow_turns != COUNT_CEILING)
                  shadow_turns++;
               shadow_dir = step_dir;
            end
         end else begin
            // Hysteresis mode: a turn needs a move beyond the tolerance.
            case (shadow_dir)
               DIR_RISE: begin
                  if (s > shadow_peak) begin
                     shadow_peak = s;
                  end else if (longint'(shadow_peak) - longint'(s) > longint'(tol_setting)) begin
                     shadow_dir  = DIR_FALL;
                     shadow_peak = s;
                     if (shadow_turns != COUNT_CEILING) shadow_turns++;
                  end
               end
               DIR_FALL: begin
                  if (s <= shadow_peak) begin
                     shadow_peak = s;
                  end else if (longint'(s) - longint'(shadow_peak) > longint'(tol_setting)) begin
                     shadow_dir  = DIR_RISE;
                     shadow_peak = s;
                     if (shadow_turns != COUNT_CEILING) shadow_turns++;
                  end
               end
               default: begin
                  if (s > shadow_max) shadow_max = s;
                  else if (s < shadow_min) shadow_min = s;
                  if (longint'(shadow_max) - longint'(shadow_min) > longint'(tol_setting)) begin
                     shadow_dir  = (s == shadow_max) ? DIR_RISE : DIR_FALL;
                     shadow_peak = s;
                  end
               end
            endcase
         end
         shadow_prev = s;
      end
      if (r.last_of_series) begin
         expected_counts.push_back(shadow_turns);
         shadow_open = 1'b0;
      end
   endfunction

   // Offers one request, waits for it to be taken, then idles for a random gap unless in burst mode.
   task automatic send_request(input logic signed [31:0] sample, input bit first,
                               input bit last);
      req_type r;
      int      gap;
      r.sample          = sample;
      r.first_of_series = first;
      r.last_of_series  = last;
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_series_step(r);
      gap = burst_mode ? 0 : pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drains the block, lets the pipeline settle, then writes the tolerance.
   task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tol_setting = value;
   endtask

   // Draws the next sample of a series from the previous one.
   function automatic logic signed [31:0] next_sample(input shape_type shape,
                                                      input logic signed [31:0] prev);
      longint v;
      longint scale;
      case (shape)
         SHAPE_RANDOM: return $urandom;
         SHAPE_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         SHAPE_WALK: begin
            scale = (tol_setting == 0) ? 64'd16 : longint'(tol_setting);
            v = longint'(prev) + longint'($urandom_range(0, 32'(2 * scale))) - scale;
         end
         default: begin
            // Step to just inside, exactly at, or just beyond the tolerance.
            scale = longint'(tol_setting) + $urandom_range(0, 2) - 1;
            v = $urandom_range(0, 1) ? longint'(prev) + scale : longint'(prev) - scale;
         end
      endcase
      if (v > SAMPLE_TOP) v = SAMPLE_TOP;
      if (v < SAMPLE_FLOOR) v = SAMPLE_FLOOR;
      return 32'(v);
   endfunction

   // Every accepted result is checked against the oldest expected count.
   always @(posedge clock) begin : check_results
      logic [OUT_COUNT_BITS-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("result with no open request", rsp_payload.extrema_count, -1);
         end else begin
            want = expected_counts.pop_front();
            if (rsp_payload.extrema_count !== want)
               report_mismatch("extrema_count", rsp_payload.extrema_count, want);
            if (rsp_payload.is_final !== 1'b1)
               report_mismatch("is_final", rsp_payload.is_final, 1);
         end
      end
   end

   // Result-side stall: random stretches, plus one long hold-off on request.
   initial begin : drive_rsp_stall
      int n;
      forever begin
         if (hold_pending) begin
            rsp_stall   <= 1'b1;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
            hold_active  = 1'b0;
         end
         n = pick_gap(rx_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (pick_gap(rx_calm) + 1) @(posedge clock);
      end
   end

   // Strict counting after reset: no open series, flat steps, extremes, one-sample series.
   task automatic test_directed_strict();
      send_request(32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'sh8000_0000, 1'b0, 1'b0);
      send_request(32'sh8000_0000, 1'b0, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0, 1'b1);
      send_request(32'sd5, 1'b1, 1'b1);
      // The series is closed, so this one opens a new one on its own.
      send_request(-32'sd1, 1'b0, 1'b0);
      send_request(32'sd1, 1'b0, 1'b0);
      send_request(32'sd0, 1'b0, 1'b1);
   endtask

   // Hysteresis counting: widest tolerance, a series that never decides, a mid-series change.
   task automatic test_directed_tolerant();
      write_tolerance('1);
      send_request(32'sh8000_0000, 1'b1, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'sd0, 1'b0, 1'b0);
      send_request(32'sh8000_0000, 1'b0, 1'b1);

      write_tolerance(31'd100);
      send_request(32'sd1000, 1'b1, 1'b0);
      send_request(32'sd1050, 1'b0, 1'b0);
      send_request(32'sd1100, 1'b0, 1'b0);
      send_request(32'sd1000, 1'b0, 1'b1);

      // Decide, turn once, and leave the series open across the tolerance write.
      send_request(32'sd1000, 1'b1, 1'b0);
      send_request(32'sd1101, 1'b0, 1'b0);
      send_request(32'sd1001, 1'b0, 1'b0);
      send_request(32'sd1000, 1'b0, 1'b0);
      write_tolerance(31'd0);
      send_request(32'sd1000, 1'b0, 1'b0);
      send_request(32'sd1200, 1'b0, 1'b0);
      send_request(32'sd900, 1'b0, 1'b1);
   endtask

   // Hold the result side off for a long time while requests keep coming.
   task automatic test_backpressure();
      int j;
      req_valid <= 1'b0;
      hold_pending = 1'b1;
      while (!hold_active) @(posedge clock);
      burst_mode = 1'b1;
      for (j = 0; j < 15; j++) begin
         send_request($urandom, 1'b1, 1'b0);
         send_request($urandom, 1'b0, 1'b0);
         send_request($urandom, 1'b0, 1'b1);
      end
      burst_mode = 1'b0;
   endtask

   // Random series under several tolerance settings, mostly well framed.
   task automatic test_random_series(input int phase_items);
      int                  phase;
      int                  sent;
      int                  len;
      int                  i;
      int                  roll;
      logic [TOL_BITS-1:0] tol;
      shape_type           shape;
      frame_type           frame;
      logic signed [31:0]  s;
      bit                  first;
      bit                  last;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       tol = '0;
            1:       tol = '1;
            2:       tol = 31'd1;
            3:       tol = TOL_BITS'($urandom_range(2, 4096));
            4:       tol = TOL_BITS'($urandom);
            5:       tol = '0;
            default: tol = TOL_BITS'(31'h0001_0000 + $urandom_range(0, 255));
         endcase
         write_tolerance(tol);
         sent = 0;
         while (sent < phase_items) begin
            roll = $urandom_range(0, 99);
            frame = (roll < 80) ? FRAME_CLEAN : (roll < 88) ? FRAME_NO_FIRST :
                    (roll < 94) ? FRAME_NO_LAST : FRAME_NOISE;
            roll = $urandom_range(0, 99);
            shape = (roll < 70) ? SHAPE_WALK : (roll < 85) ? SHAPE_EDGE :
                    (roll < 93) ? SHAPE_EXTREME : SHAPE_RANDOM;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
            s = $urandom;
            for (i = 0; i < len; i++) begin
               if (i > 0) s = next_sample(shape, s);
               first = (i == 0) && frame != FRAME_NO_FIRST;
               last  = (i == len - 1) && frame != FRAME_NO_LAST;
               if (frame == FRAME_NOISE) begin
                  first = ($urandom_range(0, 9) == 0);
                  last  = ($urandom_range(0, 9) == 0);
               end
               send_request(s, first, last);
            end
            sent += len;
         end
      end
   endtask

   // Main sequence: reset, the tests in turn, then drain and judge.
   initial begin
      tol_setting  = '0;
      shadow_prev  = '0;
      shadow_min   = '0;
      shadow_max   = '0;
      shadow_peak  = '0;
      shadow_dir   = DIR_NONE;
      shadow_turns = '0;
      shadow_open  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_strict();
      test_directed_tolerant();
      test_backpressure();
      test_random_series(230);

      // Let every outstanding result come back, then a few quiet cycles.
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_counts.size() != 0)
         report_mismatch("results never returned", 0, expected_counts.size());
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/hec_pkg.sv
hdl/hec_in_reg.sv
hdl/hec_core.sv
hdl/hec_out_reg.sv
hdl/hysteresis_extrema_counter.sv
hdl/hec_checker.sv
sim/tb.sv
